[sv/nebf_pkg.sv]
// Package for the band-image effective force block: item types, state codes and constants.
// No dependencies; used by neb_effective_force.
`timescale 1ns / 1ps

package nebf_pkg;

    // Default capacity in elements and default number of fraction bits.
    localparam int MAX_ELEMS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Climbing images double the projection term: a left shift by one.
    localparam int CLIMB_SHIFT = 1;

    // Word widths of the fixed-point values and of the dot accumulator.
    localparam int WORD_W  = 32;
    localparam int ACCUM_W = 64;

    // One input item: the element of each vector plus the image flags.
    typedef struct packed {
        logic signed [WORD_W-1:0] grad_elem;
        logic signed [WORD_W-1:0] tangent_elem;
        logic signed [WORD_W-1:0] spring_elem;
        logic                     climbing;
        logic                     last_elem;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [WORD_W-1:0] force_elem;
        logic                     last_out;
        logic                     overrun;
    } result_t;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_ACCUM = 5'b00010,
        ST_DOT   = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

endpackage

[sv/neb_effective_force.sv]
// Effective force of one nudged elastic band image, normal or climbing.
// Depends on nebf_pkg (item types, state codes, constants).
`timescale 1ns / 1ps

//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  -------------------------
//  element   in         start & !busy at clk rise   item   (nebf_pkg::in_item_t)
//  force     out        result_valid, one cycle     result (nebf_pkg::result_t)
//
//  An element is taken at a clock rise with start high and busy low; busy stays low until the last element.
//  After the last element of an image with N stored elements, busy stays high while
//  the block finishes the dot accumulation, scales it, makes N reads of the element
//  memory (one read port, one entry a cycle), then runs a three-stage drain.
//  Results leave one per cycle; the receiver cannot stall them.
//  Reset clears the sequencer, counters and accumulator; the memory is not cleared.

module neb_effective_force #(
    parameter int MAX_ELEMS = nebf_pkg::MAX_ELEMS_DEF,
    parameter int FRAC_BITS = nebf_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  nebf_pkg::in_item_t item,
    output logic               result_valid,
    output nebf_pkg::result_t  result
);

    localparam int W    = nebf_pkg::WORD_W;
    localparam int AW   = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW   = $clog2(MAX_ELEMS + 1);
    localparam int AccW = nebf_pkg::ACCUM_W;
    localparam int MemW = 3 * W;
    localparam int SumW = 2 * W + 3;
    localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMS);

    // Element memory: gradient, tangent and spring word of each element.
    logic [MemW-1:0] mem [MAX_ELEMS];

    nebf_pkg::state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic                   overrun_reg, overrun_next;
    logic                   climb_reg, climb_next;
    logic signed [AccW-1:0] accum_reg, accum_next;
    logic signed [2*W-1:0]  prod_reg;
    logic                   prod_valid_reg;
    logic signed [W-1:0]    dot_reg;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;

    // Emission pipeline: memory read, projection product, final sum.
    logic [MemW-1:0]        rdata_reg;
    logic                   v1_reg, last1_reg;
    logic signed [2*W-1:0]  proj_reg;
    logic signed [W-1:0]    g2_reg, s2_reg;
    logic                   v2_reg, last2_reg;
    logic                   result_valid_reg;
    nebf_pkg::result_t      result_reg;

    logic                   accept;
    logic                   store;
    logic                   rd_en;
    logic                   rd_last;
    logic signed [AccW:0]   accum_sum;
    logic signed [AccW-1:0] dot_shift;
    logic signed [W-1:0]    dot_sat;
    logic signed [2*W-1:0]  term;
    logic signed [SumW-1:0] term_ext;
    logic signed [SumW-1:0] force_sum;
    logic signed [W-1:0]    force_sat;

    assign accept = start && (state_reg == nebf_pkg::ST_LOAD);
    assign store  = accept && (count_reg < MaxCount);
    assign busy   = (state_reg != nebf_pkg::ST_LOAD);

    assign rd_en   = (state_reg == nebf_pkg::ST_EMIT);
    assign rd_last = ({{(CW-AW){1'b0}}, rd_addr_reg} == (count_reg - CW'(1)));

    // Saturating addition of the latest product into the dot accumulator.
    always_comb
    begin
        accum_sum = {accum_reg[AccW-1], accum_reg} + {prod_reg[2*W-1], prod_reg};
        if (accum_sum[AccW] != accum_sum[AccW-1])
        begin
            accum_next = accum_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                         : {1'b0, {(AccW-1){1'b1}}};
        end
        else
        begin
            accum_next = accum_sum[AccW-1:0];
        end
    end

    // Dot value: floor shift of the accumulator, saturated to one word.
    always_comb
    begin
        dot_shift = accum_reg >>> FRAC_BITS;
        if ((&dot_shift[AccW-1:W-1]) || !(|dot_shift[AccW-1:W-1]))
        begin
            dot_sat = dot_shift[W-1:0];
        end
        else
        begin
            dot_sat = dot_shift[AccW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    // Force element: minus gradient plus projection (doubled when climbing), plus spring unless climbing.
    always_comb
    begin
        term     = proj_reg >>> FRAC_BITS;
        term_ext = SumW'(term);
        if (climb_reg)
        begin
            term_ext  = term_ext <<< nebf_pkg::CLIMB_SHIFT;
            force_sum = term_ext - SumW'(g2_reg);
        end
        else
        begin
            force_sum = term_ext - SumW'(g2_reg) + SumW'(s2_reg);
        end
        if ((&force_sum[SumW-1:W-1]) || !(|force_sum[SumW-1:W-1]))
        begin
            force_sat = force_sum[W-1:0];
        end
        else
        begin
            force_sat = force_sum[SumW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    // Sequencer and image bookkeeping.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        overrun_next = overrun_reg;
        climb_next   = climb_reg;
        rd_addr_next = rd_addr_reg;
        unique case (state_reg)
            nebf_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (store)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        overrun_next = 1'b1;
                    end
                    if (item.last_elem)
                    begin
                        climb_next = item.climbing;
                        state_next = nebf_pkg::ST_ACCUM;
                    end
                end
            end
            nebf_pkg::ST_ACCUM:
            begin
                state_next = nebf_pkg::ST_DOT;
            end
            nebf_pkg::ST_DOT:
            begin
                rd_addr_next = '0;
                state_next   = nebf_pkg::ST_EMIT;
            end
            nebf_pkg::ST_EMIT:
            begin
                if (rd_last)
                begin
                    state_next = nebf_pkg::ST_FLUSH;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            nebf_pkg::ST_FLUSH:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    count_next   = '0;
                    overrun_next = 1'b0;
                    state_next   = nebf_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = nebf_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= nebf_pkg::ST_LOAD;
            count_reg        <= '0;
            overrun_reg      <= 1'b0;
            climb_reg        <= 1'b0;
            rd_addr_reg      <= '0;
            accum_reg        <= '0;
            prod_valid_reg   <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            overrun_reg      <= overrun_next;
            climb_reg        <= climb_next;
            rd_addr_reg      <= rd_addr_next;
            prod_valid_reg   <= store;
            v1_reg           <= rd_en;
            v2_reg           <= v1_reg;
            result_valid_reg <= v2_reg;
            if (state_reg == nebf_pkg::ST_FLUSH && state_next == nebf_pkg::ST_LOAD)
            begin
                accum_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                accum_reg <= accum_next;
            end
        end
    end

    // Element memory: written while loading, read while emitting.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[count_reg[AW-1:0]] <= {item.grad_elem, item.tangent_elem, item.spring_elem};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            prod_reg <= (2*W)'(item.grad_elem) * (2*W)'(item.tangent_elem);
        end
        if (state_reg == nebf_pkg::ST_DOT)
        begin
            dot_reg <= dot_sat;
        end
        last1_reg <= rd_last;
        proj_reg  <= (2*W)'(dot_reg) * (2*W)'($signed(rdata_reg[2*W-1:W]));
        g2_reg    <= $signed(rdata_reg[MemW-1:2*W]);
        s2_reg    <= $signed(rdata_reg[W-1:0]);
        last2_reg <= last1_reg;
        result_reg.force_elem <= force_sat;
        result_reg.last_out   <= last2_reg;
        result_reg.overrun    <= overrun_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Results only leave while an image is being emitted.
    a_result_in_emission: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside emission");

    // The stored element count never exceeds capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MaxCount)
        else $error("element count beyond capacity");

    // A product is never pending when the dot value is taken.
    a_accum_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nebf_pkg::ST_DOT) |-> !prod_valid_reg)
        else $error("dot taken before accumulation finished");

    // The final result of an image ends the strobe train.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_out) |=> !result_valid)
        else $error("result after the final element");

endmodule

[sim/tb.sv]
// Self-checking testbench for neb_effective_force: band images go in element by element,
// and each force item that comes out is compared with an in-bench prediction.
// Depends on nebf_pkg and neb_effective_force.
`timescale 1ns / 1ps

module tb;

    import nebf_pkg::*;

    localparam int     CAPACITY   = MAX_ELEMS_DEF;
    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam int     DRAIN_PAD  = CAPACITY + 10;
    localparam int     CYCLE_CAP  = 400000;
    localparam int     PRINT_CAP  = 40;
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;
    localparam longint ACC_MAX    = 64'h7fffffffffffffff;
    localparam longint ACC_MIN    = 64'h8000000000000000;
    localparam logic signed [WORD_W-1:0] W_MAX = 32'h7fffffff;
    localparam logic signed [WORD_W-1:0] W_MIN = 32'h80000000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_item_t item;
    logic     result_valid;
    result_t  result;

    // Predicted state of the block for the image being loaded.
    logic signed [WORD_W-1:0] grad_mem   [CAPACITY];
    logic signed [WORD_W-1:0] tang_mem   [CAPACITY];
    logic signed [WORD_W-1:0] spring_mem [CAPACITY];
    longint                   dot_sum;
    int                       stored_cnt;
    logic                     dropped_seen;

    // Force items still to come, oldest first.
    result_t expected_forces[$];

    int  errors;
    int  cycles;
    int  elems_sent;
    int  images_done;
    int  climb_images;
    int  overrun_images;
    int  forces_checked;
    bit  no_idle;

    neb_effective_force dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter with a hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Timed out after %0d cycles with %0d force items outstanding.",
                     cycles, expected_forces.size());
            $display("tb: errors");
            $finish;
        end
    end

    // One line per mismatch, printing stops after a while but counting does not.
    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    function automatic longint sat_add64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? ACC_MIN : ACC_MAX;
        return s;
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp_word(input longint x);
        if (x > WORD_MAX)
            return W_MAX;
        if (x < WORD_MIN)
            return W_MIN;
        return x[WORD_W-1:0];
    endfunction

    // Take one accepted element into the predicted state; on the last element
    // work out every force item of the image and clear the per-image state.
    task automatic model_take_elem(input in_item_t it);
        logic signed [WORD_W-1:0] g;
        logic signed [WORD_W-1:0] t;
        logic signed [WORD_W-1:0] gi;
        logic signed [WORD_W-1:0] ti;
        logic signed [WORD_W-1:0] si;
        longint                   dot;
        longint                   term;
        longint                   f;
        result_t                  r;
        g = it.grad_elem;
        t = it.tangent_elem;
        if (stored_cnt < CAPACITY)
        begin
            grad_mem[stored_cnt]   = g;
            tang_mem[stored_cnt]   = t;
            spring_mem[stored_cnt] = it.spring_elem;
            dot_sum = sat_add64(dot_sum, longint'(g) * longint'(t));
            stored_cnt++;
        end
        else
            dropped_seen = 1'b1;
        if (!it.last_elem)
            return;
        dot = longint'(clamp_word(dot_sum >>> FRAC));
        for (int i = 0; i < stored_cnt; i++)
        begin
            gi = grad_mem[i];
            ti = tang_mem[i];
            si = spring_mem[i];
            term = (dot * longint'(ti)) >>> FRAC;
            if (it.climbing)
                f = -longint'(gi) + 2 * term;
            else
                f = -longint'(gi) + term + longint'(si);
            r.force_elem = clamp_word(f);
            r.last_out   = (i == stored_cnt - 1);
            r.overrun    = dropped_seen;
            expected_forces.push_back(r);
        end
        images_done++;
        if (it.climbing)
            climb_images++;
        if (dropped_seen)
            overrun_images++;
        dot_sum      = 0;
        stored_cnt   = 0;
        dropped_seen = 1'b0;
    endtask

    // Every force item leaving the block is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_forces
        result_t                  want;
        logic signed [WORD_W-1:0] want_f;
        logic signed [WORD_W-1:0] got_f;
        if (rst_n && result_valid)
        begin
            got_f = result.force_elem;
            if (expected_forces.size() == 0)
                report_mismatch("force item with none expected", 0, longint'(got_f));
            else
            begin
                want = expected_forces.pop_front();
                want_f = want.force_elem;
                if (got_f !== want_f)
                    report_mismatch("force_elem", longint'(want_f), longint'(got_f));
                if (result.last_out !== want.last_out)
                    report_mismatch("last_out", longint'(want.last_out),
                                    longint'(result.last_out));
                if (result.overrun !== want.overrun)
                    report_mismatch("overrun", longint'(want.overrun),
                                    longint'(result.overrun));
                forces_checked++;
            end
        end
    end

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Fixed-point word: extremes, small values around zero, or anything at all.
    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '0;
            3, 4, 5: return $urandom_range(0, 1 << 19) - (1 << 18);
            default: return $urandom;
        endcase
    endfunction

    // Present one element after a random pause and hold it until it is taken.
    task automatic send_elem(input logic signed [WORD_W-1:0] g,
                             input logic signed [WORD_W-1:0] t,
                             input logic signed [WORD_W-1:0] s,
                             input logic climb, input logic last);
        in_item_t it;
        int       gap;
        it.grad_elem    = g;
        it.tangent_elem = t;
        it.spring_elem  = s;
        it.climbing     = climb;
        it.last_elem    = last;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model_take_elem(it);
        elems_sent++;
    endtask

    // One image of random content; the climbing flag is random on every element.
    task automatic send_rand_image(input int n_elems);
        for (int i = 0; i < n_elems; i++)
            send_elem(rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                      i == n_elems - 1);
    endtask

    // Stop offering items and let every predicted force item arrive.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_forces.size() != 0)
            @(posedge clk);
    endtask

    // Single-element images at the word extremes, then a small normal image.
    task automatic test_extremes();
        send_elem('0, '0, '0, 1'b0, 1'b1);
        send_elem(W_MIN, '0, W_MAX, 1'b0, 1'b1);
        send_elem(W_MAX, '0, W_MIN, 1'b0, 1'b1);
        send_elem(32'sh0001_0000, 32'sh0000_8000, 32'sh0000_1000, 1'b0, 1'b0);
        send_elem(-32'sh0002_0000, 32'sh0001_0000, -32'sh0000_4000, 1'b0, 1'b0);
        send_elem(32'sh0000_4000, -32'sh0000_C000, 32'sh0003_0000, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Dot accumulator driven into positive and then negative saturation.
    task automatic test_saturation();
        for (int i = 0; i < 5; i++)
            send_elem(W_MIN, W_MIN, W_MAX, 1'b0, i == 4);
        for (int i = 0; i < 5; i++)
            send_elem(W_MIN, W_MAX, 32'sh0000_0100, 1'b1, i == 4);
        wait_idle();
    endtask

    // Only the flag on the last element decides whether the image climbs.
    task automatic test_climbing();
        send_elem(32'sh0001_8000, 32'sh0002_0000, 32'sh0005_0000, 1'b1, 1'b0);
        send_elem(-32'sh0000_8000, 32'sh0000_4000, -32'sh0001_0000, 1'b1, 1'b0);
        send_elem(32'sh0003_0000, -32'sh0001_0000, 32'sh0000_2000, 1'b0, 1'b1);
        send_elem(32'sh0001_8000, 32'sh0002_0000, 32'sh0005_0000, 1'b0, 1'b0);
        send_elem(-32'sh0000_8000, 32'sh0000_4000, -32'sh0001_0000, 1'b0, 1'b0);
        send_elem(32'sh0003_0000, -32'sh0001_0000, 32'sh0000_2000, 1'b1, 1'b1);
        wait_idle();
    endtask

    // An image that fills the store and runs past it: the extra elements are
    // dropped, the last among them.
    task automatic test_capacity();
        no_idle = 1'b0;
        send_rand_image(CAPACITY + 2);
        wait_idle();
    endtask

    // Random images, mostly short, some longer, with stretches of no idling.
    task automatic test_random();
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < 40)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                n = $urandom_range(1, 6);
            else if (r < 95)
                n = $urandom_range(7, 20);
            else
                n = $urandom_range(21, 32);
            no_idle = ($urandom_range(0, 3) == 0);
            send_rand_image(n);
            sent += n;
            if ($urandom_range(0, 4) == 0)
                wait_idle();
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        errors         = 0;
        cycles         = 0;
        elems_sent     = 0;
        images_done    = 0;
        climb_images   = 0;
        overrun_images = 0;
        forces_checked = 0;
        no_idle        = 1'b0;
        dot_sum        = 0;
        stored_cnt     = 0;
        dropped_seen   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_saturation();
        test_climbing();
        test_capacity();
        test_random();

        // Allow the block to finish any drain, then look for stray or missing items.
        repeat (DRAIN_PAD) @(posedge clk);
        if (expected_forces.size() != 0)
            report_mismatch("force items never delivered", 0, expected_forces.size());

        $display("Covered %0d elements in %0d images (%0d climbing, %0d over capacity).",
                 elems_sent, images_done, climb_images, overrun_images);
        $display("Checked %0d force items in %0d cycles, %0d mismatches.",
                 forces_checked, cycles, errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
sv/nebf_pkg.sv
sv/neb_effective_force.sv
sim/tb.sv
